### sv/psab_pkg.sv
`timescale 1ns / 1ps

package psab_pkg;

  localparam int SCREEN_COLUMNS = 256;
  localparam int SCREEN_ROWS    = 256;
  localparam int PIX_COUNT      = SCREEN_COLUMNS * SCREEN_ROWS;

  localparam int COL_W  = $clog2(SCREEN_COLUMNS);
  localparam int ROW_W  = $clog2(SCREEN_ROWS);
  localparam int ADDR_W = $clog2(PIX_COUNT);

  localparam int COLOR_W = 24;
  localparam int ALPHA_W = 8;
  localparam int CLIP_W  = 9;
  localparam int POS_W   = 11;
  localparam int CFG_IDX_W = 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // input mode codes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_BLEND = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM = 2'd3;

  localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [ALPHA_W-1:0] ALPHA_CLEAR  = 8'h00;

  typedef enum logic [1:0] {
    OP_DROP  = 2'd0,
    OP_WRITE = 2'd1,
    OP_BLEND = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
    logic [ALPHA_W-1:0] alpha;
  } item_t;

endpackage

### sv/psab_front.sv
`timescale 1ns / 1ps

module psab_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [psab_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psab_pkg::CLIP_W-1:0]          cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_mode,
  input  logic signed [psab_pkg::POS_W-1:0]    in_pos_x,
  input  logic signed [psab_pkg::POS_W-1:0]    in_pos_y,
  input  logic [psab_pkg::COLOR_W-1:0]         in_pixel_color,
  input  logic [psab_pkg::ALPHA_W-1:0]         in_blend_alpha,
  input  logic                                 clearing,
  input  logic                                 q_full,
  output logic                                 push,
  output psab_pkg::item_t                      push_item
);
  import psab_pkg::*;

  logic [CLIP_W-1:0] clip_left_r, clip_top_r, clip_right_r, clip_bottom_r;
  logic              fr_valid_r, fr_valid_nxt;
  item_t             fr_item_r, fr_item_nxt;

  logic signed [POS_W:0] xs, ys;
  logic                  vis, in_clip, in_acc;
  logic [COL_W-1:0]      x_u;
  logic [ROW_W-1:0]      y_u;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_left_r   <= '0;
      clip_top_r    <= '0;
      clip_right_r  <= CLIP_W'(256);
      clip_bottom_r <= CLIP_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CLIP_LEFT:   clip_left_r   <= cfg_wdata;
        REG_CLIP_TOP:    clip_top_r    <= cfg_wdata;
        REG_CLIP_RIGHT:  clip_right_r  <= cfg_wdata;
        REG_CLIP_BOTTOM: clip_bottom_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    xs = {in_pos_x[POS_W-1], in_pos_x};
    ys = {in_pos_y[POS_W-1], in_pos_y};
    vis = (xs >= 0) && (xs < $signed((POS_W+1)'(SCREEN_COLUMNS))) &&
          (ys >= 0) && (ys < $signed((POS_W+1)'(SCREEN_ROWS)));
    in_clip = (xs >= $signed({3'b000, clip_left_r})) &&
              (xs <  $signed({3'b000, clip_right_r})) &&
              (ys >= $signed({3'b000, clip_top_r})) &&
              (ys <  $signed({3'b000, clip_bottom_r}));
    x_u = in_pos_x[COL_W-1:0];
    y_u = in_pos_y[ROW_W-1:0];

    fr_item_nxt.addr  = ADDR_W'(y_u) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(x_u);
    fr_item_nxt.color = in_pixel_color;
    fr_item_nxt.alpha = in_blend_alpha;
    case (in_mode)
      MODE_WRITE: fr_item_nxt.op = (vis && in_clip) ? OP_WRITE : OP_DROP;
      MODE_BLEND: fr_item_nxt.op = (vis && in_clip) ? OP_BLEND : OP_DROP;
      MODE_READ:  fr_item_nxt.op = vis ? OP_READ : OP_DROP;
      default:    fr_item_nxt.op = OP_DROP;
    endcase
  end

  assign push     = fr_valid_r && !q_full;
  assign in_stall = clearing || (fr_valid_r && q_full);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    if (in_acc) begin
      fr_valid_nxt = 1'b1;
    end else if (push) begin
      fr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      fr_item_r <= fr_item_nxt;
    end
  end

  assign push_item = fr_item_r;

endmodule

### sv/psab_queue.sv
`timescale 1ns / 1ps

module psab_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  psab_pkg::item_t push_item,
  input  logic            pop,
  output psab_pkg::item_t head_item,
  output logic            full,
  output logic            empty
);
  import psab_pkg::*;

  item_t             slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full      = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign head_item = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !(pop && !empty)) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop && !empty) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### sv/psab_back.sv
`timescale 1ns / 1ps

module psab_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  psab_pkg::item_t               head_item,
  output logic                          pop,
  output logic                          clearing,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [psab_pkg::COLOR_W-1:0]  out_read_color,
  output logic                          out_accepted
);
  import psab_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_SUM  = 5'b00100,
    S_EST  = 5'b01000,
    S_FIX  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [COLOR_W-1:0] mem [PIX_COUNT];
  logic [COLOR_W-1:0] rd_data_r;
  logic               rd_en, wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [COLOR_W-1:0] wr_data;

  logic              clearing_r;
  logic [ADDR_W-1:0] clr_addr_r;

  item_t cur_r;

  logic [15:0] prod_old_r [3];
  logic [15:0] prod_new_r [3];
  logic [15:0] sum_r      [3];
  logic [7:0]  q_r        [3];
  logic [15:0] prod_old   [3];
  logic [15:0] prod_new   [3];
  logic [15:0] sum_c      [3];
  logic [7:0]  q_est      [3];
  logic [15:0] rem        [3];
  logic [23:0] est_prod   [3];
  logic [COLOR_W-1:0] mixed;

  logic               out_valid_r;
  logic [COLOR_W-1:0] out_color_r;
  logic               out_ok_r;
  logic               slot_free;
  logic               res_set;
  logic [COLOR_W-1:0] res_color;
  logic               res_ok;

  assign slot_free = !out_valid_r || !out_stall;
  assign clearing  = clearing_r;

  // per-channel blend arithmetic; divide by 255 as multiply by 257, then fix up by one
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod_old[c] = 16'(rd_data_r[8*c +: 8]) * 16'(ALPHA_OPAQUE - cur_r.alpha);
      prod_new[c] = 16'(cur_r.color[8*c +: 8]) * 16'(cur_r.alpha);
      sum_c[c]    = prod_old_r[c] + prod_new_r[c];
      est_prod[c] = 24'(sum_r[c]) * 24'(257);
      q_est[c]    = est_prod[c][23:16];
      rem[c]      = sum_r[c] - ((16'(q_r[c]) << 8) - 16'(q_r[c]));
      mixed[8*c +: 8] = (rem[c] >= 16'd255) ? q_r[c] + 8'd1 : q_r[c];
    end
  end

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = cur_r.addr;
    wr_data   = mixed;
    res_set   = 1'b0;
    res_color = '0;
    res_ok    = 1'b0;
    if (clearing_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty && slot_free) begin
            pop = 1'b1;
            unique case (head_item.op) inside
              OP_WRITE: begin
                wr_en   = 1'b1;
                wr_addr = head_item.addr;
                wr_data = head_item.color;
                res_set = 1'b1;
                res_ok  = 1'b1;
              end
              OP_READ, OP_BLEND: begin
                rd_en     = 1'b1;
                state_nxt = S_READ;
              end
              default: begin
                res_set = 1'b1;
              end
            endcase
          end
        end
        S_READ: begin
          state_nxt = S_IDLE;
          if (cur_r.op == OP_READ) begin
            res_set   = 1'b1;
            res_color = rd_data_r;
            res_ok    = 1'b1;
          end else if (cur_r.alpha == ALPHA_OPAQUE) begin
            wr_en   = 1'b1;
            wr_data = cur_r.color;
            res_set = 1'b1;
            res_ok  = 1'b1;
          end else if (cur_r.alpha == ALPHA_CLEAR) begin
            res_set = 1'b1;
            res_ok  = 1'b1;
          end else begin
            state_nxt = S_SUM;
          end
        end
        S_SUM: state_nxt = S_EST;
        S_EST: state_nxt = S_FIX;
        S_FIX: begin
          wr_en     = 1'b1;
          res_set   = 1'b1;
          res_ok    = 1'b1;
          state_nxt = S_IDLE;
        end
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[head_item.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == ADDR_W'(PIX_COUNT - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      if (res_set) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head_item;
    end
    if (res_set) begin
      out_color_r <= res_color;
      out_ok_r    <= res_ok;
    end
    for (int c = 0; c < 3; c++) begin
      if (state_r == S_READ) begin
        prod_old_r[c] <= prod_old[c];
        prod_new_r[c] <= prod_new[c];
      end
      if (state_r == S_SUM) begin
        sum_r[c] <= sum_c[c];
      end
      if (state_r == S_EST) begin
        q_r[c] <= q_est[c];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_color = out_color_r;
  assign out_accepted   = out_ok_r;

endmodule

### sv/pixel_store_alpha_blend_top.sv
`timescale 1ns / 1ps
// Path from input accept to result: the front register and the queue, then dropped words and plain writes
// set the result on pop, reads and blends with alpha 0 or 255 in S_READ, other blends via S_SUM, S_EST, S_FIX.
// Throughput: one word per cycle for dropped words and plain writes while out_stall is low; a read or
// blend holds the back end until its result is set, so no new word is taken from the queue meanwhile.
// Reset: clip rectangle goes to the full screen, then a clearing pass writes black to all
// SCREEN_COLUMNS*SCREEN_ROWS (65536) pixels; in_stall stays high meanwhile.
module pixel_store_alpha_blend_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [psab_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psab_pkg::CLIP_W-1:0]          cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_mode,
  input  logic signed [psab_pkg::POS_W-1:0]    in_pos_x,
  input  logic signed [psab_pkg::POS_W-1:0]    in_pos_y,
  input  logic [psab_pkg::COLOR_W-1:0]         in_pixel_color,
  input  logic [psab_pkg::ALPHA_W-1:0]         in_blend_alpha,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [psab_pkg::COLOR_W-1:0]         out_read_color,
  output logic                                 out_accepted
);
  import psab_pkg::*;

  logic  clearing, q_full, q_empty, push, pop;
  item_t push_item, head_item;

  psab_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pixel_color (in_pixel_color),
    .in_blend_alpha (in_blend_alpha),
    .clearing       (clearing),
    .q_full         (q_full),
    .push           (push),
    .push_item      (push_item)
  );

  psab_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  psab_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .head_item      (head_item),
    .pop            (pop),
    .clearing       (clearing),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_color (out_read_color),
    .out_accepted   (out_accepted)
  );

endmodule
